// File: design/htk_pkg.sv
`timescale 1ns / 1ps

// Shared types and constants for the HTTP request head tokenizer.
package htk_pkg;

    // Default width of the byte counters.
    localparam int COUNT_WIDTH_DEF = 13;

    // Fixed field widths.
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 13;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register map: the index bit of the byte address selects the register.
    localparam logic REG_IDX_MAX_LENGTH = 1'b0;

    // Configuration values.
    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 13'd1024;
    localparam logic [LEN_W-1:0] MAX_LENGTH_MIN   = 13'd2;

    // Character codes.
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;

    // CR LF CR LF closes the head.
    localparam logic [4*BYTE_W-1:0] HEAD_END = 32'h0D0A0D0A;

    // Parse phases.
    typedef enum logic [3:0] {
        PH_METHOD  = 4'd0,
        PH_GAP1    = 4'd1,
        PH_TARGET  = 4'd2,
        PH_GAP2    = 4'd3,
        PH_VERSION = 4'd4,
        PH_NAME    = 4'd5,
        PH_GAP3    = 4'd6,
        PH_VALUE   = 4'd7,
        PH_TRAIL   = 4'd8
    } phase_t;

    // Byte classes.
    typedef enum logic [2:0] {
        CLS_SEP     = 3'd0,
        CLS_METHOD  = 3'd1,
        CLS_TARGET  = 3'd2,
        CLS_VERSION = 3'd3,
        CLS_NAME    = 3'd4,
        CLS_VALUE   = 3'd5
    } token_class_t;

    // Head status.
    typedef enum logic [1:0] {
        ST_MORE = 2'd0,
        ST_DONE = 2'd1,
        ST_LONG = 2'd2,
        ST_BAD  = 2'd3
    } status_t;

    // One result item.
    typedef struct packed {
        logic [LEN_W-1:0] head_length;
        status_t          status;
        logic             token_end;
        token_class_t     token_class;
    } result_t;

endpackage

// File: design/htk_cfg.sv
`timescale 1ns / 1ps

// APB register block holding max_length and deriving the line and head limits.
module htk_cfg #(
    parameter int COUNT_WIDTH = htk_pkg::COUNT_WIDTH_DEF,
    parameter int CMP_W = ((COUNT_WIDTH > htk_pkg::LEN_W) ? COUNT_WIDTH : htk_pkg::LEN_W) + 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [htk_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [htk_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [htk_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [CMP_W-1:0]                line_lim,
    output logic [CMP_W-1:0]                head_lim
);

    logic [htk_pkg::LEN_W-1:0] max_length_reg;
    logic [htk_pkg::LEN_W-1:0] max_length_next;
    logic                      sel_max_length;
    logic [htk_pkg::LEN_W-1:0] eff_len;
    logic [CMP_W-1:0]          eff_wide;
    logic [CMP_W-1:0]          eff_m1;
    logic [CMP_W-1:0]          count_max;

    assign pready         = 1'b1;
    assign sel_max_length = (paddr[2] == htk_pkg::REG_IDX_MAX_LENGTH);

    // Register write on the access cycle of a write transaction.
    always_comb begin
        max_length_next = max_length_reg;
        if (psel && penable && pwrite && pready && sel_max_length) begin
            max_length_next = pwdata[htk_pkg::LEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= htk_pkg::MAX_LENGTH_RESET;
        end else begin
            max_length_reg <= max_length_next;
        end
    end

    // Read data.
    assign prdata = sel_max_length ? htk_pkg::APB_DATA_W'(max_length_reg) : '0;

    // Limits: small values act as the minimum, and both are capped at the counter maximum.
    assign count_max = {{(CMP_W-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};
    assign eff_len   = (max_length_reg < htk_pkg::MAX_LENGTH_MIN) ?
                       htk_pkg::MAX_LENGTH_MIN : max_length_reg;
    assign eff_wide  = CMP_W'(eff_len);
    assign eff_m1    = eff_wide - CMP_W'(1);
    assign line_lim  = (eff_wide > count_max) ? count_max : eff_wide;
    assign head_lim  = (eff_m1 > count_max) ? count_max : eff_m1;

endmodule

// File: design/htk_core.sv
`timescale 1ns / 1ps

// Parse state and the per-byte classification, one byte per step.
module htk_core #(
    parameter int COUNT_WIDTH = htk_pkg::COUNT_WIDTH_DEF,
    parameter int CMP_W = ((COUNT_WIDTH > htk_pkg::LEN_W) ? COUNT_WIDTH : htk_pkg::LEN_W) + 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [htk_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        start_of_message,
    input  logic [CMP_W-1:0]            line_lim,
    input  logic [CMP_W-1:0]            head_lim,
    output htk_pkg::result_t            result
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    htk_pkg::phase_t              phase_reg, phase_next, phase_cur;
    htk_pkg::status_t             sticky_reg, sticky_next, sticky_cur;
    logic [COUNT_WIDTH-1:0]       head_reg, head_next, head_cur;
    logic [COUNT_WIDTH-1:0]       line_reg, line_next, line_cur;
    logic                         tok_seen_reg, tok_seen_next, tok_seen_cur;
    logic                         absorb_reg, absorb_next, absorb_cur;
    logic [3*htk_pkg::BYTE_W-1:0] recent_reg, recent_next, recent_cur;
    logic [4*htk_pkg::BYTE_W-1:0] win;
    logic                         is_brk;
    logic                         is_sp;
    logic                         is_colon;
    htk_pkg::token_class_t        cls;
    logic                         tend;
    htk_pkg::status_t             st;

    assign is_brk   = (data_byte == htk_pkg::CH_CR) || (data_byte == htk_pkg::CH_LF);
    assign is_sp    = (data_byte == htk_pkg::CH_SP) || (data_byte == htk_pkg::CH_TAB);
    assign is_colon = (data_byte == htk_pkg::CH_COLON);

    // Start of message clears the parse state before this byte is looked at.
    always_comb begin
        if (start_of_message) begin
            phase_cur    = htk_pkg::PH_METHOD;
            sticky_cur   = htk_pkg::ST_MORE;
            head_cur     = '0;
            line_cur     = '0;
            tok_seen_cur = 1'b0;
            absorb_cur   = 1'b0;
            recent_cur   = '0;
        end else begin
            phase_cur    = phase_reg;
            sticky_cur   = sticky_reg;
            head_cur     = head_reg;
            line_cur     = line_reg;
            tok_seen_cur = tok_seen_reg;
            absorb_cur   = absorb_reg;
            recent_cur   = recent_reg;
        end
    end

    assign win = {recent_cur, data_byte};

    // Next state and result for the byte at hand.
    always_comb begin
        phase_next    = phase_cur;
        sticky_next   = sticky_cur;
        head_next     = head_cur;
        line_next     = line_cur;
        tok_seen_next = tok_seen_cur;
        absorb_next   = absorb_cur;
        recent_next   = recent_cur;
        cls           = htk_pkg::CLS_SEP;
        tend          = 1'b0;
        st            = htk_pkg::ST_MORE;

        if (sticky_cur != htk_pkg::ST_MORE) begin
            st = sticky_cur;
        end else begin
            head_next   = (head_cur == COUNT_MAX) ? head_cur : head_cur + COUNT_WIDTH'(1);
            recent_next = win[3*htk_pkg::BYTE_W-1:0];

            if (win == htk_pkg::HEAD_END) begin
                st = htk_pkg::ST_DONE;
            end else if (CMP_W'(head_next) >= head_lim) begin
                st = htk_pkg::ST_LONG;
            end else if (absorb_cur && is_brk) begin
                absorb_next = 1'b0;
            end else begin
                absorb_next = 1'b0;
                if (phase_cur == htk_pkg::PH_TRAIL || phase_cur > htk_pkg::PH_VALUE) begin
                    // After the empty line only completion and the head limit matter.
                end else if (is_brk) begin
                    if (line_cur == '0) begin
                        phase_next  = htk_pkg::PH_TRAIL;
                        absorb_next = 1'b1;
                    end else if (phase_cur == htk_pkg::PH_VERSION ||
                                 phase_cur == htk_pkg::PH_VALUE ||
                                 phase_cur == htk_pkg::PH_GAP3) begin
                        // A version or non-empty value is closed by the break.
                        tend          = (phase_cur != htk_pkg::PH_GAP3);
                        phase_next    = htk_pkg::PH_NAME;
                        line_next     = '0;
                        tok_seen_next = 1'b0;
                        absorb_next   = 1'b1;
                    end else begin
                        st = htk_pkg::ST_BAD;
                    end
                end else begin
                    line_next = (line_cur == COUNT_MAX) ? line_cur : line_cur + COUNT_WIDTH'(1);
                    if (CMP_W'(line_next) >= line_lim) begin
                        st = htk_pkg::ST_LONG;
                    end else begin
                        unique case (phase_cur)
                            htk_pkg::PH_METHOD: begin
                                if (is_sp) begin
                                    if (!tok_seen_cur) begin
                                        st = htk_pkg::ST_BAD;
                                    end else begin
                                        tend          = 1'b1;
                                        phase_next    = htk_pkg::PH_GAP1;
                                        tok_seen_next = 1'b0;
                                    end
                                end else begin
                                    cls           = htk_pkg::CLS_METHOD;
                                    tok_seen_next = 1'b1;
                                end
                            end
                            htk_pkg::PH_GAP1: begin
                                if (!is_sp) begin
                                    cls        = htk_pkg::CLS_TARGET;
                                    phase_next = htk_pkg::PH_TARGET;
                                end
                            end
                            htk_pkg::PH_TARGET: begin
                                if (is_sp) begin
                                    tend       = 1'b1;
                                    phase_next = htk_pkg::PH_GAP2;
                                end else begin
                                    cls = htk_pkg::CLS_TARGET;
                                end
                            end
                            htk_pkg::PH_GAP2: begin
                                if (!is_sp) begin
                                    cls        = htk_pkg::CLS_VERSION;
                                    phase_next = htk_pkg::PH_VERSION;
                                end
                            end
                            htk_pkg::PH_VERSION: begin
                                cls = htk_pkg::CLS_VERSION;
                            end
                            htk_pkg::PH_NAME: begin
                                if (is_colon) begin
                                    tend       = 1'b1;
                                    phase_next = htk_pkg::PH_GAP3;
                                end else begin
                                    cls = htk_pkg::CLS_NAME;
                                end
                            end
                            htk_pkg::PH_GAP3: begin
                                if (!(is_sp || is_colon)) begin
                                    cls        = htk_pkg::CLS_VALUE;
                                    phase_next = htk_pkg::PH_VALUE;
                                end
                            end
                            default: begin
                                cls = htk_pkg::CLS_VALUE;
                            end
                        endcase
                    end
                end
            end

            // Any final status sticks and blanks the classification.
            if (st != htk_pkg::ST_MORE) begin
                sticky_next = st;
                cls         = htk_pkg::CLS_SEP;
                tend        = 1'b0;
            end
        end
    end

    // Result fields.
    always_comb begin
        result.token_class = cls;
        result.token_end   = tend;
        result.status      = st;
        result.head_length = (st == htk_pkg::ST_DONE) ? htk_pkg::LEN_W'(head_next) : '0;
    end

    // State registers advance once per processed byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= htk_pkg::PH_METHOD;
            sticky_reg   <= htk_pkg::ST_MORE;
            head_reg     <= '0;
            line_reg     <= '0;
            tok_seen_reg <= 1'b0;
            absorb_reg   <= 1'b0;
            recent_reg   <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            sticky_reg   <= sticky_next;
            head_reg     <= head_next;
            line_reg     <= line_next;
            tok_seen_reg <= tok_seen_next;
            absorb_reg   <= absorb_next;
            recent_reg   <= recent_next;
        end
    end

endmodule

// File: design/http_request_head_tokenizer.sv
`timescale 1ns / 1ps

// HTTP request head tokenizer: takes one byte of a request head per clock on the
// s_ stream while the result stream is not stalled and returns, for every byte, its
// token class, a token end flag, the sticky head status and, on completion, the
// head length including CR LF CR LF. A byte is registered at acceptance and its
// result is registered when the held byte advances into the result register, so
// new bytes keep being taken as long as results are drained.
// Setting s_tuser high with a byte clears the parse state before that byte.
// The user writes max_length over APB only while the stream is idle; the block does not enforce it.
module http_request_head_tokenizer #(
    parameter int COUNT_WIDTH = htk_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] data_byte
    input  logic [0:0]                      s_tuser,   // [0] start_of_message
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,   // [2:0] token_class, [3] token_end,
                                                       // [5:4] status, [18:6] head_length
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [htk_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [htk_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [htk_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int CMP_W = ((COUNT_WIDTH > htk_pkg::LEN_W) ? COUNT_WIDTH : htk_pkg::LEN_W) + 1;

    logic                       in_valid_reg, in_valid_next;
    logic [htk_pkg::BYTE_W-1:0] in_byte_reg;
    logic                       in_som_reg;
    logic                       out_valid_reg, out_valid_next;
    htk_pkg::result_t           out_reg;
    htk_pkg::result_t           core_result;
    logic                       advance;
    logic [CMP_W-1:0]           line_lim;
    logic [CMP_W-1:0]           head_lim;

    htk_cfg #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .CMP_W       (CMP_W)
    ) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .line_lim (line_lim),
        .head_lim (head_lim)
    );

    htk_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .CMP_W       (CMP_W)
    ) u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (advance),
        .data_byte        (in_byte_reg),
        .start_of_message (in_som_reg),
        .line_lim         (line_lim),
        .head_lim         (head_lim),
        .result           (core_result)
    );

    // The held byte moves on when the result register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Pipeline control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_som_reg  <= s_tuser[0];
        end
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_reg.head_length, out_reg.status,
                       out_reg.token_end, out_reg.token_class};

    // A finished head always spans at least the four closing bytes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.status == htk_pkg::ST_DONE) |-> (out_reg.head_length >= 13'd4))
        else $error("head complete with a length below four bytes");

    // A final status never comes with a token class or token end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.status != htk_pkg::ST_MORE) |->
        (out_reg.token_class == htk_pkg::CLS_SEP && !out_reg.token_end))
        else $error("token tagged on a byte with a final status");

    // With both stages full and the result stalled no new byte may be taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while the pipeline is stalled and full");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import htk_pkg::*;

    localparam int CNT_MAX = (1 << COUNT_WIDTH_DEF) - 1;
    localparam int ITEMS_PER_PHASE = 230;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_LENGTH = {REG_IDX_MAX_LENGTH, 2'b00};
    localparam logic [63:0] VERSION_TEXT = "HTTP/1.1";

    // Register settings walked after the reset phase, extremes included.
    localparam int LEN_SETTINGS [7] = '{2, 4096, 64, 1, 300, 20, 1024};

    // One byte to send, with an optional fixed expectation.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              som;
        logic              typed;
        result_t           want;
    } stim_t;

    localparam result_t WANT_BAD = '{head_length: '0, status: ST_BAD,
                                     token_end: 1'b0, token_class: CLS_SEP};
    localparam result_t WANT_METHOD = '{head_length: '0, status: ST_MORE,
                                        token_end: 1'b0, token_class: CLS_METHOD};

    // Directed bytes: a short complete head, sticky status, and the malformed cases.
    stim_t directed_rows [25] = '{
        '{CH_SP,    1'b1, 1'b1, WANT_BAD},      // empty method
        '{8'hFF,    1'b0, 1'b1, WANT_BAD},      // sticky after error
        '{"G",      1'b1, 1'b1, WANT_METHOD},   // new message
        '{CH_SP,    1'b0, 1'b0, '0},
        '{CH_TAB,   1'b0, 1'b0, '0},
        '{"/",      1'b0, 1'b0, '0},
        '{CH_SP,    1'b0, 1'b0, '0},
        '{"H",      1'b0, 1'b0, '0},
        '{CH_CR,    1'b0, 1'b0, '0},
        '{CH_LF,    1'b0, 1'b0, '0},            // absorbed break
        '{CH_COLON, 1'b0, 1'b0, '0},            // empty header name
        '{CH_COLON, 1'b0, 1'b0, '0},
        '{"v",      1'b0, 1'b0, '0},
        '{CH_LF,    1'b0, 1'b0, '0},
        '{"B",      1'b0, 1'b0, '0},
        '{CH_COLON, 1'b0, 1'b0, '0},
        '{CH_CR,    1'b0, 1'b0, '0},            // empty header value
        '{CH_LF,    1'b0, 1'b0, '0},
        '{CH_CR,    1'b0, 1'b0, '0},
        '{CH_LF,    1'b0, 1'b0, '0},            // head complete
        '{"Z",      1'b0, 1'b0, '0},
        '{"G",      1'b1, 1'b1, WANT_METHOD},
        '{CH_CR,    1'b0, 1'b1, WANT_BAD},      // line ends before the target
        '{CH_LF,    1'b1, 1'b0, '0},            // blank line at the start
        '{8'h00,    1'b0, 1'b0, '0}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow of the tokenizer state and its register.
    logic [LEN_W-1:0]           max_len_cfg = MAX_LENGTH_RESET;
    phase_t                     phase_q = PH_METHOD;
    logic [COUNT_WIDTH_DEF-1:0] head_cnt = '0;
    logic [COUNT_WIDTH_DEF-1:0] line_cnt = '0;
    logic [COUNT_WIDTH_DEF-1:0] tok_cnt = '0;
    logic                       absorb_brk = 1'b0;
    logic [23:0]                recent_q = '0;
    status_t                    sticky_st = ST_MORE;

    result_t    expected_q [$];
    stim_t      plan [$];
    int         errors = 0;
    logic       msg_first;
    int         corrupt_at;
    logic [7:0] corrupt_byte;

    // Receiver stall pattern state.
    int         rx_mode = 0;
    int         rx_left = 0;
    int         rx_tick = 0;

    http_request_head_tokenizer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] data_byte
        .s_tuser  (s_tuser),    // [0] start_of_message
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [2:0] token_class, [3] token_end, [5:4] status,
                                // [18:6] head_length
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // Counters stop at their largest value.
    function automatic logic [COUNT_WIDTH_DEF-1:0] count_up(logic [COUNT_WIDTH_DEF-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic void close_line();
        phase_q = PH_NAME;
        line_cnt = '0;
        tok_cnt = '0;
        absorb_brk = 1'b1;
    endfunction

    // Classifies one accepted byte and advances the shadow state.
    function automatic result_t classify_byte(logic [7:0] b, logic som);
        int          eff;
        int          line_lim;
        int          head_lim;
        logic [31:0] win;
        logic        brk;
        logic        blank;
        phase_t      ph;
        result_t     r;
        eff = (max_len_cfg < MAX_LENGTH_MIN) ? int'(MAX_LENGTH_MIN) : int'(max_len_cfg);
        line_lim = (eff > CNT_MAX) ? CNT_MAX : eff;
        head_lim = (eff - 1 > CNT_MAX) ? CNT_MAX : eff - 1;
        brk = (b == CH_CR) || (b == CH_LF);
        blank = (b == CH_SP) || (b == CH_TAB);
        r = '0;
        if (som) begin
            phase_q = PH_METHOD;
            head_cnt = '0;
            line_cnt = '0;
            tok_cnt = '0;
            absorb_brk = 1'b0;
            recent_q = '0;
            sticky_st = ST_MORE;
        end
        // A settled status repeats until the next message starts.
        if (sticky_st != ST_MORE) begin
            r.status = sticky_st;
            r.head_length = (sticky_st == ST_DONE) ? head_cnt : '0;
            return r;
        end
        head_cnt = count_up(head_cnt);
        win = {recent_q, b};
        recent_q = win[23:0];
        if (win == HEAD_END) begin
            r.status = ST_DONE;
        end else if (head_cnt >= head_lim) begin
            r.status = ST_LONG;
        end else if (absorb_brk && brk) begin
            absorb_brk = 1'b0;
        end else begin
            ph = (phase_q > PH_VALUE) ? PH_TRAIL : phase_q;
            absorb_brk = 1'b0;
            // After the blank line only completion and the head limit apply.
            if (ph != PH_TRAIL) begin
                if (brk) begin
                    if (line_cnt == 0) begin
                        phase_q = PH_TRAIL;
                        absorb_brk = 1'b1;
                    end else if (ph == PH_VERSION || ph == PH_VALUE) begin
                        r.token_end = 1'b1;
                        close_line();
                    end else if (ph == PH_GAP3) begin
                        close_line();
                    end else begin
                        r.status = ST_BAD;
                    end
                end else begin
                    line_cnt = count_up(line_cnt);
                    if (line_cnt >= line_lim) begin
                        r.status = ST_LONG;
                    end else begin
                        case (ph)
                            PH_METHOD: begin
                                if (!blank) begin
                                    r.token_class = CLS_METHOD;
                                    tok_cnt = count_up(tok_cnt);
                                end else if (tok_cnt == 0) begin
                                    r.status = ST_BAD;
                                end else begin
                                    r.token_end = 1'b1;
                                    phase_q = PH_GAP1;
                                    tok_cnt = '0;
                                end
                            end
                            PH_GAP1: begin
                                if (!blank) begin
                                    r.token_class = CLS_TARGET;
                                    phase_q = PH_TARGET;
                                    tok_cnt = COUNT_WIDTH_DEF'(1);
                                end
                            end
                            PH_TARGET: begin
                                if (blank) begin
                                    r.token_end = 1'b1;
                                    phase_q = PH_GAP2;
                                    tok_cnt = '0;
                                end else begin
                                    r.token_class = CLS_TARGET;
                                    tok_cnt = count_up(tok_cnt);
                                end
                            end
                            PH_GAP2: begin
                                if (!blank) begin
                                    r.token_class = CLS_VERSION;
                                    phase_q = PH_VERSION;
                                    tok_cnt = COUNT_WIDTH_DEF'(1);
                                end
                            end
                            PH_VERSION: begin
                                r.token_class = CLS_VERSION;
                                tok_cnt = count_up(tok_cnt);
                            end
                            PH_NAME: begin
                                if (b == CH_COLON) begin
                                    r.token_end = 1'b1;
                                    phase_q = PH_GAP3;
                                    tok_cnt = '0;
                                end else begin
                                    r.token_class = CLS_NAME;
                                    tok_cnt = count_up(tok_cnt);
                                end
                            end
                            PH_GAP3: begin
                                if (!(blank || b == CH_COLON)) begin
                                    r.token_class = CLS_VALUE;
                                    phase_q = PH_VALUE;
                                    tok_cnt = COUNT_WIDTH_DEF'(1);
                                end
                            end
                            default: begin
                                r.token_class = CLS_VALUE;
                                tok_cnt = count_up(tok_cnt);
                            end
                        endcase
                    end
                end
            end
        end
        if (r.status != ST_MORE) begin
            sticky_st = r.status;
            r.token_class = CLS_SEP;
            r.token_end = 1'b0;
        end
        r.head_length = (r.status == ST_DONE) ? head_cnt : '0;
        return r;
    endfunction

    // Appends one byte to the plan, applying the message start and any corruption.
    function automatic void push_byte(logic [7:0] b);
        stim_t it;
        it = '0;
        it.data = (plan.size() == corrupt_at) ? corrupt_byte : b;
        it.som = msg_first;
        msg_first = 1'b0;
        plan.push_back(it);
    endfunction

    // A random byte that is never a line break, optionally never blank or colon.
    function automatic logic [7:0] token_byte(logic allow_blank, logic allow_colon);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == CH_CR || b == CH_LF ||
                   (!allow_blank && (b == CH_SP || b == CH_TAB)) ||
                   (!allow_colon && b == CH_COLON));
        return b;
    endfunction

    function automatic void push_blanks(int lo, int hi, logic with_colon);
        repeat ($urandom_range(lo, hi)) begin
            case ($urandom_range(0, with_colon ? 2 : 1))
                0: push_byte(CH_SP);
                1: push_byte(CH_TAB);
                default: push_byte(CH_COLON);
            endcase
        end
    endfunction

    function automatic void push_break();
        case ($urandom_range(0, 5))
            0: push_byte(CH_LF);
            1: push_byte(CH_CR);
            2: begin
                push_byte(CH_LF);
                push_byte(CH_CR);
            end
            default: begin
                push_byte(CH_CR);
                push_byte(CH_LF);
            end
        endcase
    endfunction

    // Builds one request head: mostly well formed, some corrupted, some noise.
    function automatic void add_message();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        msg_first = 1'b1;
        corrupt_at = (kind < 20) ? plan.size() + $urandom_range(0, 40) : -1;
        case ($urandom_range(0, 4))
            0: corrupt_byte = CH_CR;
            1: corrupt_byte = CH_LF;
            2: corrupt_byte = CH_SP;
            3: corrupt_byte = CH_COLON;
            default: corrupt_byte = 8'($urandom_range(0, 255));
        endcase
        if (kind < 8) begin
            repeat ($urandom_range(1, 30)) begin
                msg_first = msg_first | ($urandom_range(0, 15) == 0);
                push_byte(8'($urandom_range(0, 255)));
            end
            return;
        end
        // Request line.
        repeat ($urandom_range(1, 8)) push_byte(token_byte(1'b0, 1'b1));
        push_blanks(1, 3, 1'b0);
        repeat ($urandom_range(1, 24)) push_byte(token_byte(1'b0, 1'b1));
        push_blanks(1, 3, 1'b0);
        if ($urandom_range(0, 1) == 1) begin
            for (int i = 7; i >= 0; i--) push_byte(VERSION_TEXT[8*i +: 8]);
        end else begin
            repeat ($urandom_range(1, 10)) push_byte(token_byte(1'b1, 1'b1));
        end
        push_break();
        // Header lines; a few lack the colon and a few carry a long value.
        repeat ($urandom_range(0, 5)) begin
            repeat ($urandom_range(0, 12)) push_byte(token_byte(1'b1, 1'b0));
            if ($urandom_range(0, 19) != 0) begin
                push_byte(CH_COLON);
                push_blanks(0, 3, 1'b1);
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(150, 400)
                                                 : $urandom_range(0, 24);
                repeat (n) push_byte(token_byte(1'b1, 1'b1));
            end
            push_break();
        end
        // Head terminator, sometimes missing, sometimes followed by extra bytes.
        if ($urandom_range(0, 9) != 0) begin
            push_byte(CH_CR);
            push_byte(CH_LF);
            push_byte(CH_CR);
            push_byte(CH_LF);
        end else begin
            push_break();
        end
        if (kind >= 90) begin
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    // Fills the plan with whole messages and cuts it to the exact byte count.
    function automatic void fill_plan(int count);
        while (plan.size() < count) add_message();
        if (plan.size() > count) plan = plan[0:count-1];
    endfunction

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Sends the planned bytes in bursts with gaps, pausing once until drained.
    task automatic play_plan();
        int      burst;
        int      mid;
        stim_t   it;
        result_t pred;
        burst = 0;
        mid = plan.size() / 2;
        for (int i = 0; i < plan.size(); i++) begin
            if (burst == 0 || i == mid) begin
                s_tvalid <= 1'b0;
                if (i == mid) wait_drained();
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 24);
            end
            it = plan[i];
            s_tvalid <= 1'b1;
            s_tdata <= it.data;
            s_tuser <= it.som;
            do @(posedge aclk); while (!s_tready);
            // The transaction completes at this edge; the shadow state always advances.
            pred = classify_byte(it.data, it.som);
            expected_q.push_back(it.typed ? it.want : pred);
            burst--;
        end
        s_tvalid <= 1'b0;
        plan.delete();
    endtask

    // APB write of max_length: setup cycle, then access cycle.
    task automatic write_max_length(int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_MAX_LENGTH;
        pwdata <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        max_len_cfg = LEN_W'(value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Receiver stalls: always ready, mostly ready, periodic, or mostly stalled.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(32, 400);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ((rx_tick % 7) > 2);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[18:0]);
            if (expected_q.size() == 0) begin
                $error("Result transaction with no expectation waiting: tdata %h", m_tdata);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.token_class != want.token_class) begin
                    $error("token_class mismatch: expected %0d, actual %0d",
                           want.token_class, got.token_class);
                    errors++;
                end
                if (got.token_end != want.token_end) begin
                    $error("token_end mismatch: expected %0d, actual %0d",
                           want.token_end, got.token_end);
                    errors++;
                end
                if (got.status != want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, got.status);
                    errors++;
                end
                if (got.head_length != want.head_length) begin
                    $error("head_length mismatch: expected %0d, actual %0d",
                           want.head_length, got.head_length);
                    errors++;
                end
            end
            if (m_tdata[23:19] != '0) begin
                $error("tdata padding mismatch: expected 0, actual %h", m_tdata[23:19]);
                errors++;
            end
        end
    end

    // Watchdog for a hung run.
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // Main sequence: reset, directed bytes, then random phases per register setting.
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[k]) plan.push_back(directed_rows[k]);
        play_plan();
        fill_plan(ITEMS_PER_PHASE);
        play_plan();
        foreach (LEN_SETTINGS[k]) begin
            settle();
            write_max_length(LEN_SETTINGS[k]);
            fill_plan(ITEMS_PER_PHASE);
            play_plan();
        end
        settle();
        if (errors == 0 && expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/htk_pkg.sv
design/htk_cfg.sv
design/htk_core.sv
design/http_request_head_tokenizer.sv
bench/testbench.sv
